// ----- sv/kwhm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwhm_pkg
// Types, constants and codes shared by the k-way heap merge modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kwhm_pkg;

    localparam int MAX_LANES  = 16;
    localparam int VALUE_BITS = 32;
    localparam int LANE_BITS  = 4;
    localparam int IDX_BITS   = 4;
    localparam int CNT_BITS   = 5;
    localparam int CFG_BITS   = 5;
    localparam int NODE_BITS  = VALUE_BITS + LANE_BITS + 1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] element_value;
        logic                         lane_has_element;
        logic                         lane_final;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] out_value;
        logic                         value_valid;
        logic [LANE_BITS-1:0]         source_lane;
        logic                         wants_input;
        logic [LANE_BITS-1:0]         request_lane;
        logic                         merge_done;
        logic                         run_last;
    } out_t;

    // heap node: biased key (sign flipped, compares unsigned), lane, final flag
    typedef struct packed {
        logic [VALUE_BITS-1:0] key;
        logic [LANE_BITS-1:0]  lane;
        logic                  fin;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_CHECK,
        S_UP_CMP,
        S_AFTER_PUSH,
        S_DRAIN,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_L,
        S_DN_LCMP,
        S_DN_RCMP,
        S_DN_SWAP,
        S_POP_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CUR,
        WR_RDATA,
        WR_BEST
    } wr_sel_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_PRIME,
        EM_EMPTY,
        EM_POP
    } emit_t;

    typedef struct packed {
        logic    latch_in;
        logic    prime_inc;
        logic    push_start;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    idx_to_parent;
        logic    idx_to_sel;
        logic    take_top;
        logic    take_cur;
        logic    best_init;
        logic    cmp_left;
        logic    cmp_right;
        emit_t   emit;
    } cmd_t;

    typedef struct packed {
        logic                priming;
        logic                prime_open;
        logic                has;
        logic                full;
        logic                idx_zero;
        logic                parent_le;
        logic                count_zero;
        logic                count_one;
        logic                left_in;
        logic                right_in;
        logic                sel_is_idx;
        logic                out_free;
        logic                pop_ends;
        logic [CNT_BITS-1:0] count;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/kwhm_ram.sv -----
// ----------------------------------------------------------------------------
// kwhm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/kwhm_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwhm_ctrl
// Sequencer for priming, sift-up pushes, sift-down pops and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_ctrl
    import kwhm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_AFTER_PUSH;
                if (st.priming)
                begin
                    if (st.prime_open)
                    begin
                        cmd.prime_inc = 1'b1;
                        if (st.has && !st.full)
                        begin
                            cmd.push_start = 1'b1;
                            state_next     = S_UP_CHECK;
                        end
                    end
                end
                else if (st.has && !st.full)
                begin
                    cmd.push_start = 1'b1;
                    state_next     = S_UP_CHECK;
                end
            end
            S_UP_CHECK:
            begin
                if (st.idx_zero)
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_AFTER_PUSH;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (st.parent_le)
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_AFTER_PUSH;
                end
                else
                begin
                    cmd.wr_sel        = WR_RDATA;
                    cmd.idx_to_parent = 1'b1;
                    state_next        = S_UP_CHECK;
                end
            end
            S_AFTER_PUSH:
            begin
                if (st.priming && st.prime_open)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit   = EM_PRIME;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (st.count_zero)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit   = EM_EMPTY;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_sel = RD_ROOT;
                    state_next = S_POP_ROOT;
                end
            end
            S_POP_ROOT:
            begin
                cmd.take_top = 1'b1;
                if (st.count_one)
                begin
                    state_next = S_POP_EMIT;
                end
                else
                begin
                    cmd.rd_sel = RD_LAST;
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST:
            begin
                cmd.take_cur = 1'b1;
                state_next   = S_DN_L;
            end
            S_DN_L:
            begin
                cmd.best_init = 1'b1;
                if (st.left_in)
                begin
                    cmd.rd_sel = RD_LEFT;
                    state_next = S_DN_LCMP;
                end
                else
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_POP_EMIT;
                end
            end
            S_DN_LCMP:
            begin
                cmd.cmp_left = 1'b1;
                if (st.right_in)
                begin
                    cmd.rd_sel = RD_RIGHT;
                    state_next = S_DN_RCMP;
                end
                else
                begin
                    state_next = S_DN_SWAP;
                end
            end
            S_DN_RCMP:
            begin
                cmd.cmp_right = 1'b1;
                state_next    = S_DN_SWAP;
            end
            S_DN_SWAP:
            begin
                if (st.sel_is_idx)
                begin
                    cmd.wr_sel = WR_CUR;
                    state_next = S_POP_EMIT;
                end
                else
                begin
                    cmd.wr_sel     = WR_BEST;
                    cmd.idx_to_sel = 1'b1;
                    state_next     = S_DN_L;
                end
            end
            S_POP_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = EM_POP;
                    state_next = st.pop_ends ? S_IDLE : S_DRAIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/kwhm_dp.sv -----
// ----------------------------------------------------------------------------
// kwhm_dp
// Heap datapath: node RAM, sift registers, merge counters, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_dp
    import kwhm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire in_t                 in_data,
    input  wire logic [CFG_BITS-1:0] lanes,
    input  wire cmd_t                cmd,
    output stat_t                    st,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_t                     out_data
);

    localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    in_t                 in_reg;
    node_t               cur_reg, best_reg, top_reg, rdata;
    logic [IDX_BITS-1:0] idx_reg, sel_reg;
    logic [CNT_BITS-1:0] count_reg, primed_reg;
    logic [LANE_BITS-1:0] pending_reg;
    logic                priming_reg;
    out_t                out_reg;
    out_t                out_next;
    logic                out_valid_reg;

    logic                we, re;
    logic [IDX_BITS-1:0] waddr, raddr, parent_idx;
    node_t               wdata;
    logic [IDX_BITS+1:0] left6, right6, count6;
    logic                restart;

    assign parent_idx = IDX_BITS'((idx_reg - 1'b1) >> 1);
    assign left6      = {1'b0, idx_reg, 1'b1};
    assign right6     = left6 + 1'b1;
    assign count6     = {1'b0, count_reg};

    always_comb
    begin
        re    = 1'b1;
        raddr = '0;
        case (cmd.rd_sel)
            RD_PARENT: raddr = parent_idx;
            RD_ROOT:   raddr = '0;
            RD_LAST:   raddr = IDX_BITS'(count_reg - 1'b1);
            RD_LEFT:   raddr = left6[IDX_BITS-1:0];
            RD_RIGHT:  raddr = right6[IDX_BITS-1:0];
            default:   re    = 1'b0;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        waddr = idx_reg;
        wdata = cur_reg;
        case (cmd.wr_sel)
            WR_CUR:   wdata = cur_reg;
            WR_RDATA: wdata = rdata;
            WR_BEST:  wdata = best_reg;
            default:  we    = 1'b0;
        endcase
    end

    kwhm_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (MAX_LANES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign restart = (cmd.emit == EM_EMPTY) ||
                     ((cmd.emit == EM_POP) && top_reg.fin && (count_reg == '0));

    always_comb
    begin
        out_next = '0;
        case (cmd.emit)
            EM_PRIME:
            begin
                out_next.wants_input  = 1'b1;
                out_next.request_lane = primed_reg[LANE_BITS-1:0];
                out_next.run_last     = 1'b1;
            end
            EM_EMPTY:
            begin
                out_next.wants_input = 1'b1;
                out_next.merge_done  = 1'b1;
                out_next.run_last    = 1'b1;
            end
            EM_POP:
            begin
                out_next.out_value   = top_reg.key ^ SIGN;
                out_next.value_valid = 1'b1;
                out_next.source_lane = top_reg.lane;
                if (!top_reg.fin)
                begin
                    out_next.wants_input  = 1'b1;
                    out_next.request_lane = top_reg.lane;
                    out_next.run_last     = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    out_next.wants_input = 1'b1;
                    out_next.merge_done  = 1'b1;
                    out_next.run_last    = 1'b1;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.push_start)
        begin
            cur_reg.key  <= in_reg.element_value ^ SIGN;
            cur_reg.lane <= priming_reg ? primed_reg[LANE_BITS-1:0] : pending_reg;
            cur_reg.fin  <= in_reg.lane_final;
            idx_reg      <= count_reg[IDX_BITS-1:0];
        end
        else if (cmd.take_cur)
        begin
            cur_reg <= rdata;
            idx_reg <= '0;
        end
        else if (cmd.idx_to_parent)
        begin
            idx_reg <= parent_idx;
        end
        else if (cmd.idx_to_sel)
        begin
            idx_reg <= sel_reg;
        end
        if (cmd.take_top)
        begin
            top_reg <= rdata;
        end
        if (cmd.best_init)
        begin
            best_reg <= cur_reg;
            sel_reg  <= idx_reg;
        end
        else if (cmd.cmp_left && (rdata.key < cur_reg.key))
        begin
            best_reg <= rdata;
            sel_reg  <= left6[IDX_BITS-1:0];
        end
        else if (cmd.cmp_right && (rdata.key < best_reg.key))
        begin
            best_reg <= rdata;
            sel_reg  <= right6[IDX_BITS-1:0];
        end
        if (cmd.emit != EM_NONE)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            primed_reg    <= '0;
            priming_reg   <= 1'b1;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push_start)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.take_top)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.prime_inc)
            begin
                primed_reg <= primed_reg + 1'b1;
            end
            if (restart)
            begin
                count_reg   <= '0;
                primed_reg  <= '0;
                priming_reg <= 1'b1;
                pending_reg <= '0;
            end
            else if ((cmd.emit == EM_POP) && !top_reg.fin)
            begin
                pending_reg <= top_reg.lane;
                priming_reg <= 1'b0;
            end
            if (cmd.emit != EM_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st            = '0;
        st.priming    = priming_reg;
        st.prime_open = primed_reg < lanes;
        st.has        = in_reg.lane_has_element;
        st.full       = count_reg >= CNT_BITS'(MAX_LANES);
        st.idx_zero   = idx_reg == '0;
        st.parent_le  = rdata.key <= cur_reg.key;
        st.count_zero = count_reg == '0;
        st.count_one  = count_reg == CNT_BITS'(1);
        st.left_in    = left6 < count6;
        st.right_in   = right6 < count6;
        st.sel_is_idx = sel_reg == idx_reg;
        st.out_free   = !out_valid_reg || out_ready;
        st.pop_ends   = !top_reg.fin || (count_reg == '0);
        st.count      = count_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- sv/kway_heap_merge.sv -----
// ----------------------------------------------------------------------------
// kway_heap_merge
// K-way merge of sorted signed lanes through a binary min-heap of lane heads.
// ----------------------------------------------------------------------------
// A priming request answers without a push when its lane has no element or the
// heap is full; else the new lane head sifts up. Each pop from a heap of two or
// more nodes moves the last node to the root and sifts it down (up to 3 levels
// at 16 lanes); the heap RAM has one read port, one write port and registered
// read data. One request at a time.
// Reset: priming at lane 0, empty heap, active_lanes = 16; heap RAM not cleared.
`default_nettype none

module kway_heap_merge
    import kwhm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CFG_BITS-1:0] active_lanes_reg;
    logic [CFG_BITS-1:0] lanes_eff;
    cmd_t                cmd;
    stat_t               st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lanes_reg <= CFG_BITS'(MAX_LANES);
        end
        else if (psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0))
        begin
            active_lanes_reg <= pwdata[CFG_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(32-CFG_BITS){1'b0}}, active_lanes_reg};

    always_comb
    begin
        if (active_lanes_reg == '0)
        begin
            lanes_eff = CFG_BITS'(1);
        end
        else if (active_lanes_reg > CFG_BITS'(MAX_LANES))
        begin
            lanes_eff = CFG_BITS'(MAX_LANES);
        end
        else
        begin
            lanes_eff = active_lanes_reg;
        end
    end

    kwhm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    kwhm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .lanes     (lanes_eff),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st.count <= CNT_BITS'(MAX_LANES))
        else $error("heap count overflow");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |-> (!out_valid || out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire
